### rtl/core/auto_repeat_button_counter_core_assert.svh
// assertion macros used by the checker file
`ifndef AUTO_REPEAT_BUTTON_COUNTER_CORE_ASSERT_SVH
`define AUTO_REPEAT_BUTTON_COUNTER_CORE_ASSERT_SVH

// same-cycle implication, ignored while reset is low
`define ARBC_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, ignored while reset is low
`define ARBC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ARBC_ASSERT_ALWAYS(lbl, clk, pre, post) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/core/arbc_pkg.sv
// types and constants of the auto-repeat button counter
package arbc_pkg;

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_START    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UP       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DOWN     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BOTH     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REP_UP   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_REP_DOWN = 3'd6;

    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_UP   = 2'd1;
    localparam logic [1:0] BTN_BOTH = 2'd3;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_START_VALUE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_UPPER_LIMIT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_PERIOD  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FAST_PERIOD  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_REPEATS = 3'd4;

    localparam logic [3:0] START_VALUE_RST  = 4'h5;
    localparam logic [3:0] UPPER_LIMIT_RST  = 4'd9;
    localparam logic [7:0] SLOW_PERIOD_RST  = 8'd10;
    localparam logic [7:0] FAST_PERIOD_RST  = 8'd4;
    localparam logic [7:0] SLOW_REPEATS_RST = 8'h03;

    typedef struct packed {
        logic [3:0] start_value;
        logic [3:0] upper_limit;
        logic [7:0] slow_period;
        logic [7:0] fast_period;
        logic [7:0] slow_repeats;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [7:0]        hold_count;
        logic [7:0]        repeats_done;
    } ctrl_t;

endpackage

### rtl/core/arbc_step.sv
// one tick of the mode machine: action of the current mode, then mode change
module arbc_step import arbc_pkg::*; #(
    parameter int VALUE_WIDTH = 4
) (
    input  cfg_t                   cfg,
    input  ctrl_t                  ctrl_cur,
    input  logic [VALUE_WIDTH-1:0] value_cur,
    input  logic [1:0]             buttons,
    output ctrl_t                  ctrl_nxt,
    output logic [VALUE_WIDTH-1:0] value_nxt
);

    localparam int CW = (VALUE_WIDTH > 4) ? VALUE_WIDTH : 4;

    logic [CW-1:0]          value_ext;
    logic [CW-1:0]          limit_ext;
    logic [CW-1:0]          start_ext;
    logic [VALUE_WIDTH-1:0] value_up;
    logic [VALUE_WIDTH-1:0] value_down;
    logic                   slow;
    logic [7:0]             period;
    logic                   fire;

    assign value_ext = CW'(value_cur);
    assign limit_ext = CW'(cfg.upper_limit);
    assign start_ext = CW'(cfg.start_value);

    // increments saturate at the limit, also when already above it
    assign value_up   = (value_ext < limit_ext) ? value_cur + 1'b1
                                                : limit_ext[VALUE_WIDTH-1:0];
    assign value_down = (value_cur != '0) ? value_cur - 1'b1 : '0;

    assign slow   = (ctrl_cur.repeats_done != cfg.slow_repeats);
    assign period = slow ? cfg.slow_period : cfg.fast_period;
    assign fire   = (ctrl_cur.hold_count >= period);

    always_comb begin
        ctrl_nxt  = ctrl_cur;
        value_nxt = value_cur;
        unique case (ctrl_cur.mode) inside
            MODE_START: begin
                value_nxt             = start_ext[VALUE_WIDTH-1:0];
                ctrl_nxt.repeats_done = '0;
            end
            MODE_IDLE: begin
                ctrl_nxt.hold_count   = '0;
                ctrl_nxt.repeats_done = '0;
            end
            MODE_UP: begin
                ctrl_nxt.hold_count = '0;
                value_nxt           = value_up;
            end
            MODE_DOWN: begin
                ctrl_nxt.hold_count = '0;
                value_nxt           = value_down;
            end
            MODE_BOTH: begin
                ctrl_nxt.hold_count   = '0;
                ctrl_nxt.repeats_done = '0;
                value_nxt             = '0;
            end
            MODE_REP_UP, MODE_REP_DOWN: begin
                if (fire) begin
                    value_nxt = (ctrl_cur.mode == MODE_REP_UP) ? value_up : value_down;
                    ctrl_nxt.hold_count = '0;
                    if (slow) begin
                        ctrl_nxt.repeats_done = ctrl_cur.repeats_done + 8'd1;
                    end
                end else begin
                    ctrl_nxt.hold_count = ctrl_cur.hold_count + 8'd1;
                end
            end
            default: begin
            end
        endcase

        // mode change
        if (ctrl_cur.mode == MODE_START) begin
            ctrl_nxt.mode = MODE_IDLE;
        end else if (ctrl_cur.mode > MODE_REP_DOWN) begin
            ctrl_nxt.mode = MODE_START;
        end else if (buttons == BTN_NONE) begin
            ctrl_nxt.mode = MODE_IDLE;
        end else if (buttons == BTN_BOTH) begin
            ctrl_nxt.mode = MODE_BOTH;
        end else if (ctrl_cur.mode == MODE_BOTH) begin
            ctrl_nxt.mode = MODE_IDLE;
        end else if (buttons == BTN_UP) begin
            ctrl_nxt.mode = (ctrl_cur.mode == MODE_UP || ctrl_cur.mode == MODE_REP_UP)
                            ? MODE_REP_UP : MODE_UP;
        end else begin
            ctrl_nxt.mode = (ctrl_cur.mode == MODE_DOWN || ctrl_cur.mode == MODE_REP_DOWN)
                            ? MODE_REP_DOWN : MODE_DOWN;
        end
    end

endmodule

### rtl/core/auto_repeat_button_counter_core.sv
// Auto-repeat button counter core.
// Input channel s_valid/s_ready/s_buttons carries one tick per beat: bit0 is
// the up button, bit1 the down button. Each accepted tick yields exactly one
// beat on m_valid/m_ready/m_display_value with the counter after that tick.
// The result of an accepted tick is registered and shows from the next cycle
// on. Throughput is one tick per cycle while the receiver keeps up, set by the
// combinational mode update between the state registers and the output register.
// s_ready is high whenever the output register is empty or being drained, so
// a stalled receiver holds the result and stops new ticks until it is taken.
// Configuration (cfg_we, cfg_addr, cfg_wdata) writes start_value,
// upper_limit, slow_period, fast_period and slow_repeats at indexes 0 to 4;
// other indexes are ignored. Write only while no tick is in flight.
// Reset (aresetn low, synchronous) restores the default registers 5, 9, 10,
// 4 and 3, puts the machine in its start mode with a zero counter and
// empties the output register.
module auto_repeat_button_counter_core import arbc_pkg::*; #(
    parameter int VALUE_WIDTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_buttons,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_display_value
);

    localparam int CW = (VALUE_WIDTH > 4) ? VALUE_WIDTH : 4;

    cfg_t                   cfg_reg;
    ctrl_t                  ctrl_reg;
    ctrl_t                  ctrl_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [CW-1:0]          disp_ext;
    logic [3:0]             disp_reg;
    logic                   out_valid_reg;
    logic                   in_beat;

    assign s_ready = !out_valid_reg || m_ready;
    assign in_beat = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_value  <= START_VALUE_RST;
            cfg_reg.upper_limit  <= UPPER_LIMIT_RST;
            cfg_reg.slow_period  <= SLOW_PERIOD_RST;
            cfg_reg.fast_period  <= FAST_PERIOD_RST;
            cfg_reg.slow_repeats <= SLOW_REPEATS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_START_VALUE:  cfg_reg.start_value  <= cfg_wdata[3:0];
                REG_UPPER_LIMIT:  cfg_reg.upper_limit  <= cfg_wdata[3:0];
                REG_SLOW_PERIOD:  cfg_reg.slow_period  <= cfg_wdata;
                REG_FAST_PERIOD:  cfg_reg.fast_period  <= cfg_wdata;
                REG_SLOW_REPEATS: cfg_reg.slow_repeats <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    arbc_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .cfg       (cfg_reg),
        .ctrl_cur  (ctrl_reg),
        .value_cur (value_reg),
        .buttons   (s_buttons),
        .ctrl_nxt  (ctrl_next),
        .value_nxt (value_next)
    );

    assign disp_ext = CW'(value_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.mode         <= MODE_START;
            ctrl_reg.hold_count   <= '0;
            ctrl_reg.repeats_done <= '0;
            value_reg             <= '0;
            out_valid_reg         <= 1'b0;
        end else begin
            if (in_beat) begin
                ctrl_reg      <= ctrl_next;
                value_reg     <= value_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            disp_reg <= disp_ext[3:0];
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_display_value = disp_reg;

endmodule

### rtl/core/arbc_checker.sv
// port-level checks of the auto-repeat button counter core, bound to the top
`include "auto_repeat_button_counter_core_assert.svh"

module arbc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_display_value
);

    // every accepted tick produces a result beat in the next cycle
    `ARBC_ASSERT_NEXT(a_tick_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)

    // a held result blocks new ticks
    `ARBC_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)

    // a stalled result keeps its value
    `ARBC_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready,
                      m_valid && $stable(m_display_value))

    // reset empties the output register
    `ARBC_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_valid)

endmodule

bind auto_repeat_button_counter_core arbc_checker u_arbc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_display_value (m_display_value)
);

### verif/tb.sv
// testbench for the auto-repeat button counter core: predicted display beats vs dut output
`timescale 1ns / 100ps

module tb;
    import arbc_pkg::*;

    localparam logic [1:0] BTN_DOWN = 2'd2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_SETTINGS = 9;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_START_VALUE;
    logic [7:0]            cfg_wdata = 8'd0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_buttons = BTN_NONE;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [3:0]            m_display_value;

    auto_repeat_button_counter_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_buttons       (s_buttons),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_display_value (m_display_value)
    );

    always #5 aclk = ~aclk;

    // predicted counter state and register copy
    cfg_t              regs;
    logic [MODE_W-1:0] cnt_mode;
    logic [3:0]        cnt_value;
    logic [7:0]        hold_ticks;
    logic [7:0]        steps_made;

    logic [1:0] pending_ticks[$];
    logic [3:0] expected_display[$];
    logic [3:0] predicted_display;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int ticks_sent = 0;
    int beats_checked = 0;
    int settings_applied = 0;
    int cycle_count = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic step_value(input bit go_up);
        if (go_up)
            cnt_value = (cnt_value < regs.upper_limit) ? cnt_value + 4'd1 : regs.upper_limit;
        else
            cnt_value = (cnt_value > 4'd0) ? cnt_value - 4'd1 : 4'd0;
    endtask

    task automatic hold_repeat(input bit go_up);
        bit         slow;
        logic [7:0] period;
        slow = (steps_made != regs.slow_repeats);
        period = slow ? regs.slow_period : regs.fast_period;
        if (hold_ticks >= period) begin
            step_value(go_up);
            hold_ticks = 8'd0;
            if (slow)
                steps_made = steps_made + 8'd1;
        end else begin
            hold_ticks = hold_ticks + 8'd1;
        end
    endtask

    // one tick: action of the current mode, then the mode change
    task automatic advance_counter(input logic [1:0] btn, output logic [3:0] shown);
        case (cnt_mode)
            MODE_START: begin
                cnt_value = regs.start_value;
                steps_made = 8'd0;
            end
            MODE_IDLE: begin
                hold_ticks = 8'd0;
                steps_made = 8'd0;
            end
            MODE_UP: begin
                hold_ticks = 8'd0;
                step_value(1'b1);
            end
            MODE_DOWN: begin
                hold_ticks = 8'd0;
                step_value(1'b0);
            end
            MODE_BOTH: begin
                hold_ticks = 8'd0;
                steps_made = 8'd0;
                cnt_value = 4'd0;
            end
            MODE_REP_UP: hold_repeat(1'b1);
            MODE_REP_DOWN: hold_repeat(1'b0);
            default: ;
        endcase

        if (cnt_mode == MODE_START)
            cnt_mode = MODE_IDLE;
        else if (cnt_mode > MODE_REP_DOWN)
            cnt_mode = MODE_START;
        else if (btn == BTN_NONE)
            cnt_mode = MODE_IDLE;
        else if (btn == BTN_BOTH)
            cnt_mode = MODE_BOTH;
        else if (cnt_mode == MODE_BOTH)
            cnt_mode = MODE_IDLE;
        else if (btn == BTN_UP)
            cnt_mode = (cnt_mode == MODE_UP || cnt_mode == MODE_REP_UP) ? MODE_REP_UP : MODE_UP;
        else
            cnt_mode = (cnt_mode == MODE_DOWN || cnt_mode == MODE_REP_DOWN) ?
                       MODE_REP_DOWN : MODE_DOWN;
        shown = cnt_value;
    endtask

    // driver: predicts on every accepted beat, then refills from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_counter(s_buttons, predicted_display);
                expected_display.push_back(predicted_display);
                ticks_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_buttons <= pending_ticks.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_display.size() == 0) begin
                    report_mismatch($sformatf("display beat %0d with nothing expected",
                                              m_display_value));
                end else begin
                    if (m_display_value !== expected_display[0])
                        report_mismatch($sformatf("display_value got %0d want %0d",
                                                  m_display_value, expected_display[0]));
                    void'(expected_display.pop_front());
                    beats_checked++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic queue_hold(input logic [1:0] btn, input int len);
        for (int i = 0; i < len; i++)
            pending_ticks.push_back(btn);
    endtask

    // mostly press-and-hold runs with releases, some double presses and noise
    task automatic queue_random_ticks(input int n);
        int queued;
        int pick;
        int len;
        queued = 0;
        while (queued < n) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 60);
                queue_hold($urandom_range(1) ? BTN_UP : BTN_DOWN, len);
                queued += len;
                len = $urandom_range(1, 3);
                queue_hold(BTN_NONE, len);
                queued += len;
            end else if (pick < 85) begin
                len = $urandom_range(1, 4);
                queue_hold(BTN_BOTH, len);
                queued += len;
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    pending_ticks.push_back(2'($urandom_range(3)));
                queued += len;
            end
        end
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || s_valid || expected_display.size() != 0)
            @(negedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_regs(input cfg_t c);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= REG_START_VALUE;
        cfg_wdata <= {4'd0, c.start_value};
        @(posedge aclk);
        cfg_addr <= REG_UPPER_LIMIT;
        cfg_wdata <= {4'd0, c.upper_limit};
        @(posedge aclk);
        cfg_addr <= REG_SLOW_PERIOD;
        cfg_wdata <= c.slow_period;
        @(posedge aclk);
        cfg_addr <= REG_FAST_PERIOD;
        cfg_wdata <= c.fast_period;
        @(posedge aclk);
        cfg_addr <= REG_SLOW_REPEATS;
        cfg_wdata <= c.slow_repeats;
        @(posedge aclk);
        cfg_we <= 1'b0;
        regs = c;
        settings_applied++;
    endtask

    function automatic cfg_t random_small_cfg();
        cfg_t c;
        c.start_value = 4'($urandom_range(15));
        c.upper_limit = 4'($urandom_range(15));
        c.slow_period = 8'($urandom_range(6));
        c.fast_period = 8'($urandom_range(4));
        c.slow_repeats = 8'($urandom_range(5));
        return c;
    endfunction

    initial begin
        cfg_t settings[NUM_SETTINGS];

        regs = '{START_VALUE_RST, UPPER_LIMIT_RST, SLOW_PERIOD_RST,
                 FAST_PERIOD_RST, SLOW_REPEATS_RST};
        cnt_mode = MODE_START;
        cnt_value = 4'd0;
        hold_ticks = 8'd0;
        steps_made = 8'd0;

        settings[0] = '{START_VALUE_RST, UPPER_LIMIT_RST, SLOW_PERIOD_RST,
                        FAST_PERIOD_RST, SLOW_REPEATS_RST};
        settings[1] = '{4'd0, 4'd0, 8'd0, 8'd0, 8'd0};
        settings[2] = '{4'd15, 4'd15, 8'd255, 8'd255, 8'd255};
        settings[3] = random_small_cfg();
        // start above the ceiling, no slow repeats at all
        settings[4] = '{4'd15, 4'd3, 8'd2, 8'd1, 8'd0};
        for (int i = 5; i < NUM_SETTINGS; i++)
            settings[i] = random_small_cfg();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: start load, single steps, both-zero, floor, one slow repeat
        @(negedge aclk);
        send_idle_pct = 7;
        recv_idle_pct = 86;
        pending_ticks.push_back(BTN_NONE);
        pending_ticks.push_back(BTN_UP);
        pending_ticks.push_back(BTN_NONE);
        pending_ticks.push_back(BTN_DOWN);
        pending_ticks.push_back(BTN_NONE);
        pending_ticks.push_back(BTN_BOTH);
        pending_ticks.push_back(BTN_NONE);
        pending_ticks.push_back(BTN_DOWN);
        pending_ticks.push_back(BTN_NONE);
        queue_hold(BTN_UP, 13);
        pending_ticks.push_back(BTN_DOWN);
        pending_ticks.push_back(BTN_BOTH);
        pending_ticks.push_back(BTN_NONE);
        drain();

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            write_regs(settings[p]);
            @(negedge aclk);
            send_idle_pct = (p < 3) ? 7 : (p < 6) ? 86 : 0;
            recv_idle_pct = (p < 3) ? 86 : (p < 6) ? 7 : 0;
            // long holds: repeat count wrap after lowering slow_repeats, and 8-bit periods
            if (p == 1 || p == 2)
                queue_hold(BTN_UP, 260);
            queue_random_ticks(70);
            // leave the machine mid-hold so the next setting lands on a live repeat
            queue_hold((p % 2) ? BTN_DOWN : BTN_UP, 30);
            drain();
        end

        $display("sent %0d ticks under %0d register settings", ticks_sent, settings_applied);
        $display("checked %0d display beats, %0d mismatches", beats_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
